>>> rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg: shared types and constants of the slew limited servo pwm block
// Field widths, operation and status codes, reset values and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package slp_pkg;

	// channel count and timebase width
	localparam int NUM_CHANNELS = 3;
	localparam int COUNT_BITS   = 16;
	localparam int ACTIVE_CH    = (NUM_CHANNELS < 3) ? NUM_CHANNELS : 3;
	localparam int CH_IDX_BITS  = (ACTIVE_CH > 1) ? $clog2(ACTIVE_CH) : 1;

	// field widths
	localparam int WIDTH_BITS   = 16;
	localparam int CH_BITS      = 2;
	localparam int OP_BITS      = 2;
	localparam int STATUS_BITS  = 2;
	localparam int LEVEL_BITS   = 3;
	localparam int CMP_BITS     = (COUNT_BITS > WIDTH_BITS) ? COUNT_BITS : WIDTH_BITS;

	// configuration port
	localparam int CFG_IDX_BITS = 3;

	// reset values
	localparam logic [WIDTH_BITS-1:0] RESET_WIDTH  = WIDTH_BITS'(2000);
	localparam logic [WIDTH_BITS-1:0] RESET_STEP   = WIDTH_BITS'(20);
	localparam logic [WIDTH_BITS-1:0] RESET_MIN    = WIDTH_BITS'(500);
	localparam logic [WIDTH_BITS-1:0] RESET_MAX    = WIDTH_BITS'(2500);
	localparam logic [WIDTH_BITS-1:0] RESET_PERIOD = WIDTH_BITS'(20000);

	typedef logic [WIDTH_BITS-1:0] width_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	// operation codes
	typedef enum logic [OP_BITS-1:0] {
		OP_WRITE_ONE = 2'd0,
		OP_WRITE_ALL = 2'd1,
		OP_TICK      = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_CLAMPED = 2'd1,
		ST_INVALID = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CH0_MIN = 3'd0,
		CFG_CH0_MAX = 3'd1,
		CFG_CH1_MIN = 3'd2,
		CFG_CH1_MAX = 3'd3,
		CFG_CH2_MIN = 3'd4,
		CFG_CH2_MAX = 3'd5,
		CFG_SLEW    = 3'd6,
		CFG_PERIOD  = 3'd7
	} cfg_idx_t;

	// outcome of slew limiting and clamping for one channel
	typedef struct packed {
		width_t applied;
		width_t slewed;
		logic   clamped;
		logic   slew_hit;
	} calc_res_t;

endpackage

`default_nettype wire

>>> rtl/slp_slew_clamp.sv
// ----------------------------------------------------------------------------
// slp_slew_clamp: slew limiter and window clamp
// Limits the step from the last applied width, then clamps to min and max.
// ----------------------------------------------------------------------------
`default_nettype none

module slp_slew_clamp
	import slp_pkg::*;
(
	input  wire width_t    prev,
	input  wire width_t    request,
	input  wire width_t    step,
	input  wire width_t    min_width,
	input  wire width_t    max_width,
	output calc_res_t      res
);

	width_t up_diff;
	width_t down_diff;
	width_t slewed;
	logic   hit;
	width_t after_min;

	assign up_diff   = request - prev;
	assign down_diff = prev - request;

	// limit only when the change is strictly larger than the step
	always_comb begin
		slewed = request;
		hit    = 1'b0;
		if (request > prev && up_diff > step) begin
			slewed = prev + step;
			hit    = 1'b1;
		end else if (prev > request && down_diff > step) begin
			slewed = prev - step;
			hit    = 1'b1;
		end
	end

	// min clamp first, max clamp second so max wins
	assign after_min = (slewed < min_width) ? min_width : slewed;

	always_comb begin
		res.slewed   = slewed;
		res.slew_hit = hit;
		res.applied  = (after_min > max_width) ? max_width : after_min;
		res.clamped  = (slewed < min_width) || (after_min > max_width);
	end

endmodule

`default_nettype wire

>>> rtl/slp_timebase.sv
// ----------------------------------------------------------------------------
// slp_timebase: shared period counter and active compare values
// Counts ticks, loads the compare shadows at wrap and derives output levels.
// ----------------------------------------------------------------------------
`default_nettype none

module slp_timebase
	import slp_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     tick,
	input  wire width_t             period_limit,
	input  wire width_t             shadow [ACTIVE_CH],
	output logic [LEVEL_BITS-1:0]   levels_now,
	output logic [LEVEL_BITS-1:0]   levels_next
);

	count_t count_q;
	width_t active_q [ACTIVE_CH];
	count_t count_inc;
	count_t count_next;
	logic   wrap;

	// wrap on reaching the period or on counter overflow
	assign count_inc  = count_q + COUNT_BITS'(1);
	assign wrap       = (CMP_BITS'(count_inc) >= CMP_BITS'(period_limit)) ||
	                    (count_inc == '0);
	assign count_next = wrap ? '0 : count_inc;

	// levels now and after a tick
	always_comb begin
		levels_now  = '0;
		levels_next = '0;
		for (int i = 0; i < ACTIVE_CH; i++) begin
			levels_now[i]  = CMP_BITS'(count_q) < CMP_BITS'(active_q[i]);
			levels_next[i] = CMP_BITS'(count_next) <
			                 CMP_BITS'(wrap ? shadow[i] : active_q[i]);
		end
	end

	// counter and active compare registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < ACTIVE_CH; i++) active_q[i] <= RESET_WIDTH;
		end else if (tick) begin
			count_q <= count_next;
			if (wrap) begin
				for (int i = 0; i < ACTIVE_CH; i++) active_q[i] <= shadow[i];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/slew_limited_servo_pwm.sv
// ----------------------------------------------------------------------------
// slew_limited_servo_pwm: three channel servo pwm with slew rate limiting
// Input register, per-channel slew and clamp, timebase and result register.
// ----------------------------------------------------------------------------
// Each result passes the input register and then the result register.
// Throughput: one input per cycle for single writes and ticks unless stalled;
// a write-all gives one result per channel via the single result register.
// Reset: arst_n clears all control state at once, loads the register reset
// values and sets every width and compare to 2000; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module slew_limited_servo_pwm
	import slp_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	// input stream
	input  wire                     s_tvalid,
	output logic                    s_tready,
	input  wire  [23:0]             s_tdata,   // channel[1:0], pulse_request[17:2], zero pad
	input  wire  [OP_BITS-1:0]      s_tuser,   // op[1:0]
	// result stream
	output logic                    m_tvalid,
	input  wire                     m_tready,
	output logic [39:0]             m_tdata,   // pwm_levels[2:0], result_channel[4:3],
	                                           // applied_width[20:5], slewed_width[36:21],
	                                           // status[38:37], slew_hit[39]
	output logic                    m_tlast,
	// configuration writes
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  [CFG_IDX_BITS-1:0] cfg_index,
	input  wire  [WIDTH_BITS-1:0]   cfg_data
);

	// input stage
	logic               v_s1;
	op_t                op_s1;
	logic [CH_BITS-1:0] ch_s1;
	width_t             req_s1;
	logic [CH_BITS-1:0] idx_s1;

	// configuration registers
	width_t min_q [ACTIVE_CH];
	width_t max_q [ACTIVE_CH];
	width_t slew_q;
	width_t period_q;

	// last applied width, which is also the compare shadow
	width_t last_q [ACTIVE_CH];

	logic                   out_free;
	logic                   needs_out;
	logic                   last_step;
	logic                   step;
	logic                   done;
	logic [CH_BITS-1:0]     sel_ch;
	logic                   ch_valid;
	logic [CH_IDX_BITS-1:0] sel_idx;
	width_t                 prev;
	width_t                 sel_min;
	width_t                 sel_max;
	calc_res_t              calc;
	logic [LEVEL_BITS-1:0]  levels_now;
	logic [LEVEL_BITS-1:0]  levels_next;
	logic                   is_write;
	status_t                res_status;

	assign cfg_ready = 1'b1;

	// step control of the input stage
	assign out_free  = !m_tvalid || m_tready;
	assign needs_out = (op_s1 != OP_NONE);
	assign step      = v_s1 && (!needs_out || out_free);
	assign last_step = (op_s1 != OP_WRITE_ALL) || (idx_s1 == CH_BITS'(ACTIVE_CH - 1));
	assign done      = step && last_step;
	assign s_tready  = !v_s1 || done;

	// channel selection
	assign sel_ch   = (op_s1 == OP_WRITE_ALL) ? idx_s1 : ch_s1;
	assign ch_valid = ({1'b0, sel_ch} < (CH_BITS + 1)'(ACTIVE_CH));
	assign sel_idx  = sel_ch[CH_IDX_BITS-1:0];
	assign prev     = ch_valid ? last_q[sel_idx] : '0;
	assign sel_min  = ch_valid ? min_q[sel_idx]  : '0;
	assign sel_max  = ch_valid ? max_q[sel_idx]  : '0;
	assign is_write = (op_s1 == OP_WRITE_ONE) || (op_s1 == OP_WRITE_ALL);

	slp_slew_clamp u_calc (
		.prev      (prev),
		.request   (req_s1),
		.step      (slew_q),
		.min_width (sel_min),
		.max_width (sel_max),
		.res       (calc)
	);

	slp_timebase u_timebase (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (step && (op_s1 == OP_TICK)),
		.period_limit (period_q),
		.shadow       (last_q),
		.levels_now   (levels_now),
		.levels_next  (levels_next)
	);

	// input register and write-all channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			op_s1  <= OP_NONE;
			ch_s1  <= '0;
			req_s1 <= '0;
			idx_s1 <= '0;
		end else if (s_tvalid && s_tready) begin
			v_s1   <= 1'b1;
			op_s1  <= op_t'(s_tuser);
			ch_s1  <= s_tdata[CH_BITS-1:0];
			req_s1 <= s_tdata[CH_BITS +: WIDTH_BITS];
			idx_s1 <= '0;
		end else if (done) begin
			v_s1   <= 1'b0;
		end else if (step) begin
			idx_s1 <= idx_s1 + CH_BITS'(1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACTIVE_CH; i++) begin
				min_q[i] <= RESET_MIN;
				max_q[i] <= RESET_MAX;
			end
			slew_q   <= RESET_STEP;
			period_q <= RESET_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SLEW:   slew_q   <= cfg_data;
				CFG_PERIOD: period_q <= cfg_data;
				default: begin
					for (int i = 0; i < ACTIVE_CH; i++) begin
						if (cfg_index[CFG_IDX_BITS-1:1] == (CFG_IDX_BITS - 1)'(i)) begin
							if (cfg_index[0]) max_q[i] <= cfg_data;
							else              min_q[i] <= cfg_data;
						end
					end
				end
			endcase
		end
	end

	// last applied widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACTIVE_CH; i++) last_q[i] <= RESET_WIDTH;
		end else if (step && is_write && ch_valid) begin
			last_q[sel_idx] <= calc.applied;
		end
	end

	// result status
	always_comb begin
		if (op_s1 == OP_TICK)      res_status = ST_OK;
		else if (!ch_valid)        res_status = ST_INVALID;
		else if (calc.clamped)     res_status = ST_CLAMPED;
		else                       res_status = ST_OK;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= step && needs_out;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && needs_out) begin
			m_tlast <= last_step;
			if (op_s1 == OP_TICK) begin
				m_tdata <= {1'b0, res_status, WIDTH_BITS'(0), WIDTH_BITS'(0),
				            CH_BITS'(0), levels_next};
			end else if (!ch_valid) begin
				m_tdata <= {1'b0, res_status, WIDTH_BITS'(0), WIDTH_BITS'(0),
				            sel_ch, levels_now};
			end else begin
				m_tdata <= {calc.slew_hit, res_status, calc.slewed, calc.applied,
				            sel_ch, levels_now};
			end
		end
	end

	// a write-all stays in the input stage until its last channel
	assert property (@(posedge clk) disable iff (!arst_n)
		step && (op_s1 == OP_WRITE_ALL) && !last_step |=> v_s1 && (op_s1 == OP_WRITE_ALL))
		else $error("write-all left the input stage early");

	// the channel counter only runs for write-all
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (idx_s1 != '0) |-> (op_s1 == OP_WRITE_ALL))
		else $error("channel counter moved outside write-all");

	// an invalid channel result is always the last of its input
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[38:37] == ST_INVALID) |-> m_tlast)
		else $error("invalid channel result not marked last");

	// no new transfer may overwrite an unfinished input
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && v_s1 |-> done)
		else $error("input stage overwritten");

endmodule

`default_nettype wire

>>> bench/pwm_result_checker.sv
// ----------------------------------------------------------------------------
// pwm_result_checker: result predictor and comparator for the servo pwm block
// Watches the input, configuration and result streams, keeps its own copy of
// the limits, widths, compare values and timebase, and checks every result
// field against the oldest predicted result.
// ----------------------------------------------------------------------------
module pwm_result_checker
	import slp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [23:0]             s_tdata,   // channel[1:0], pulse_request[17:2], zero pad
	input  logic [OP_BITS-1:0]      s_tuser,   // op[1:0]
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic [39:0]             m_tdata,   // pwm_levels[2:0], result_channel[4:3],
	                                           // applied_width[20:5], slewed_width[36:21],
	                                           // status[38:37], slew_hit[39]
	input  logic                    m_tlast,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [WIDTH_BITS-1:0]   cfg_data,
	output int                      fail_count,
	output int                      pending
);

	typedef struct {
		logic [LEVEL_BITS-1:0] levels;
		logic [CH_BITS-1:0]    chan;
		width_t                applied;
		width_t                slewed;
		status_t               status;
		logic                  hit;
		logic                  last;
	} pwm_result_t;

	// predicted results still waiting for their transfer
	pwm_result_t due_results[$];

	// copy of the limits and of the block state
	width_t min_w [ACTIVE_CH];
	width_t max_w [ACTIVE_CH];
	width_t slew_step;
	width_t period_len;
	width_t last_w [ACTIVE_CH];
	width_t shadow_cmp [ACTIVE_CH];
	width_t active_cmp [ACTIVE_CH];
	count_t counter;

	function automatic logic [LEVEL_BITS-1:0] levels_now();
		logic [LEVEL_BITS-1:0] lv;
		lv = '0;
		for (int i = 0; i < ACTIVE_CH; i++)
			if (counter < active_cmp[i])
				lv[i] = 1'b1;
		return lv;
	endfunction

	// slew limit, then min clamp, then max clamp (max wins)
	task automatic step_channel(int ch, width_t req, logic last_flag);
		int prev, want, step, slewed, applied;
		pwm_result_t r;
		prev   = int'(last_w[ch]);
		want   = int'(req);
		step   = int'(slew_step);
		slewed = want;
		r.hit  = 1'b0;
		r.status = ST_OK;
		if (want > prev && want - prev > step) begin
			slewed = prev + step;
			r.hit  = 1'b1;
		end else if (prev > want && prev - want > step) begin
			slewed = prev - step;
			r.hit  = 1'b1;
		end
		applied = slewed;
		if (applied < int'(min_w[ch])) begin
			applied  = int'(min_w[ch]);
			r.status = ST_CLAMPED;
		end
		if (applied > int'(max_w[ch])) begin
			applied  = int'(max_w[ch]);
			r.status = ST_CLAMPED;
		end
		last_w[ch]     = width_t'(applied);
		shadow_cmp[ch] = width_t'(applied);
		r.levels  = levels_now();
		r.chan    = CH_BITS'(ch);
		r.applied = width_t'(applied);
		r.slewed  = width_t'(slewed);
		r.last    = last_flag;
		due_results.push_back(r);
	endtask

	// counter step with wrap, compare shadows taken over at the wrap
	task automatic advance_timebase();
		count_t nxt;
		pwm_result_t r;
		nxt = counter + COUNT_BITS'(1);
		if (nxt >= period_len || nxt == '0) begin
			nxt = '0;
			for (int i = 0; i < ACTIVE_CH; i++)
				active_cmp[i] = shadow_cmp[i];
		end
		counter   = nxt;
		r.levels  = levels_now();
		r.chan    = '0;
		r.applied = '0;
		r.slewed  = '0;
		r.status  = ST_OK;
		r.hit     = 1'b0;
		r.last    = 1'b1;
		due_results.push_back(r);
	endtask

	task automatic predict_item(op_t op, logic [CH_BITS-1:0] ch, width_t req);
		pwm_result_t r;
		case (op)
			OP_WRITE_ONE: begin
				if (ch >= ACTIVE_CH) begin
					r.levels  = levels_now();
					r.chan    = ch;
					r.applied = '0;
					r.slewed  = '0;
					r.status  = ST_INVALID;
					r.hit     = 1'b0;
					r.last    = 1'b1;
					due_results.push_back(r);
				end else begin
					step_channel(int'(ch), req, 1'b1);
				end
			end
			OP_WRITE_ALL: begin
				for (int i = 0; i < ACTIVE_CH; i++)
					step_channel(i, req, i == ACTIVE_CH - 1);
			end
			OP_TICK: advance_timebase();
			default: ;
		endcase
	endtask

	task automatic write_register(cfg_idx_t idx, width_t val);
		case (idx)
			CFG_CH0_MIN: min_w[0] = val;
			CFG_CH0_MAX: max_w[0] = val;
			CFG_CH1_MIN: min_w[1] = val;
			CFG_CH1_MAX: max_w[1] = val;
			CFG_CH2_MIN: min_w[2] = val;
			CFG_CH2_MAX: max_w[2] = val;
			CFG_SLEW:    slew_step = val;
			CFG_PERIOD:  period_len = val;
			default: ;
		endcase
	endtask

	task automatic check_field(string name, logic [WIDTH_BITS-1:0] want,
			logic [WIDTH_BITS-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// watch all three channels; results are popped before new items are predicted
	always @(posedge clk or negedge arst_n) begin
		pwm_result_t got;
		pwm_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < ACTIVE_CH; i++) begin
				min_w[i]      = RESET_MIN;
				max_w[i]      = RESET_MAX;
				last_w[i]     = RESET_WIDTH;
				shadow_cmp[i] = RESET_WIDTH;
				active_cmp[i] = RESET_WIDTH;
			end
			slew_step  = RESET_STEP;
			period_len = RESET_PERIOD;
			counter    = '0;
			due_results.delete();
		end else begin
			if ($isunknown(m_tvalid)) begin
				$error("m_tvalid is unknown out of reset");
				fail_count++;
			end
			if (m_tvalid && m_tready) begin
				got.levels  = m_tdata[2:0];
				got.chan    = m_tdata[4:3];
				got.applied = m_tdata[20:5];
				got.slewed  = m_tdata[36:21];
				got.status  = status_t'(m_tdata[38:37]);
				got.hit     = m_tdata[39];
				got.last    = m_tlast;
				if (due_results.size() == 0) begin
					$error("result transfer with no result predicted");
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("pwm_levels", WIDTH_BITS'(want.levels),
						WIDTH_BITS'(got.levels));
					check_field("result_channel", WIDTH_BITS'(want.chan),
						WIDTH_BITS'(got.chan));
					check_field("applied_width", want.applied, got.applied);
					check_field("slewed_width", want.slewed, got.slewed);
					check_field("status", WIDTH_BITS'(want.status),
						WIDTH_BITS'(got.status));
					check_field("slew_hit", WIDTH_BITS'(want.hit), WIDTH_BITS'(got.hit));
					check_field("last", WIDTH_BITS'(want.last), WIDTH_BITS'(got.last));
				end
			end
			if (cfg_valid && cfg_ready)
				write_register(cfg_idx_t'(cfg_index), cfg_data);
			if (s_tvalid && s_tready)
				predict_item(op_t'(s_tuser), s_tdata[1:0], s_tdata[17:2]);
		end
		pending = due_results.size();
	end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the slew limited servo pwm block
// Directed writes, ticks and limit settings first, then random phases with
// random limits, slew step and period, mostly under random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
	import slp_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [23:0]             s_tdata;   // channel[1:0], pulse_request[17:2], zero pad
	logic [OP_BITS-1:0]      s_tuser;   // op[1:0]
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [39:0]             m_tdata;   // pwm_levels[2:0], result_channel[4:3],
	                                    // applied_width[20:5], slewed_width[36:21],
	                                    // status[38:37], slew_hit[39]
	logic                    m_tlast;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [WIDTH_BITS-1:0]   cfg_data;

	int     fail_count;
	int     pending;
	bit     quiet = 1'b0;
	bit     gaps_on = 1'b1;
	int     hold_left = 0;
	width_t cfg_vals [8];

	slew_limited_servo_pwm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pwm_result_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	// result side stalls in random bursts between ready runs
	always @(negedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			m_tready  <= 1'b0;
			hold_left <= $urandom_range(0, 9);
		end else begin
			m_tready  <= 1'b1;
			hold_left <= $urandom_range(0, 30);
		end
	end

	// one input transfer, with an optional gap in front; valid stays high after
	task automatic send_item(op_t op, logic [CH_BITS-1:0] ch, width_t req);
		if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'b0, req, ch};
		do @(posedge clk); while (s_tready !== 1'b1);
		@(negedge clk);
	endtask

	// hold off input until every predicted result has arrived, then idle
	// through the block latency, then write all registers back to back
	task automatic commit_settings();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= cfg_vals[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(width_t min0, width_t max0, width_t min1, width_t max1,
			width_t min2, width_t max2, width_t slew, width_t period);
		cfg_vals[CFG_CH0_MIN] = min0;
		cfg_vals[CFG_CH0_MAX] = max0;
		cfg_vals[CFG_CH1_MIN] = min1;
		cfg_vals[CFG_CH1_MAX] = max1;
		cfg_vals[CFG_CH2_MIN] = min2;
		cfg_vals[CFG_CH2_MAX] = max2;
		cfg_vals[CFG_SLEW]    = slew;
		cfg_vals[CFG_PERIOD]  = period;
		commit_settings();
	endtask

	// mostly small widths near the period, now and then an extreme
	function automatic width_t pick_width();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		else if (sel == 1)
			return '1;
		else if (sel == 2)
			return width_t'($urandom);
		return width_t'($urandom_range(0, 80));
	endfunction

	task automatic random_settings();
		width_t lo, hi, tmp;
		int sel;
		for (int c = 0; c < ACTIVE_CH; c++) begin
			lo = pick_width();
			hi = pick_width();
			// min above max is kept only now and then
			if (lo > hi && $urandom_range(0, 3) != 0) begin
				tmp = lo;
				lo  = hi;
				hi  = tmp;
			end
			cfg_vals[2 * c]     = lo;
			cfg_vals[2 * c + 1] = hi;
		end
		sel = $urandom_range(0, 9);
		if (sel == 0)
			cfg_vals[CFG_SLEW] = '0;
		else if (sel == 1)
			cfg_vals[CFG_SLEW] = '1;
		else if (sel == 2)
			cfg_vals[CFG_SLEW] = width_t'($urandom);
		else
			cfg_vals[CFG_SLEW] = width_t'($urandom_range(1, 30));
		sel = $urandom_range(0, 9);
		if (sel == 0)
			cfg_vals[CFG_PERIOD] = '0;
		else if (sel == 1)
			cfg_vals[CFG_PERIOD] = '1;
		else if (sel == 2)
			cfg_vals[CFG_PERIOD] = width_t'($urandom);
		else
			cfg_vals[CFG_PERIOD] = width_t'($urandom_range(1, 64));
		commit_settings();
	endtask

	// random mix of ticks, writes, invalid channels and ignored ops
	task automatic random_burst(int count);
		int          done_items;
		int          sel;
		op_t         op;
		logic [1:0]  ch;
		width_t      req;
		done_items = 0;
		while (done_items < count) begin
			sel = $urandom_range(0, 99);
			ch  = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 2) == 0)
				req = width_t'($urandom);
			else
				req = width_t'($urandom_range(0, 80));
			if (sel < 40)
				op = OP_TICK;
			else if (sel < 70)
				op = OP_WRITE_ONE;
			else if (sel < 88)
				op = OP_WRITE_ALL;
			else
				op = OP_NONE;
			send_item(op, ch, req);
			if (op != OP_NONE)
				done_items++;
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_NONE;
		cfg_valid = 1'b0;
		cfg_index = CFG_CH0_MIN;
		cfg_data  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset limits: slew hits up and down, one tick
		send_item(OP_WRITE_ONE, 2'd0, 16'd2100);
		send_item(OP_WRITE_ONE, 2'd1, 16'd0);
		send_item(OP_TICK, 2'd0, 16'd0);

		// open, narrow and inverted windows, no slew limit, short period
		apply_settings(16'd0, 16'hFFFF, 16'd100, 16'd200, 16'd3000, 16'd1000,
			16'hFFFF, 16'd7);
		send_item(OP_WRITE_ALL, 2'd0, 16'hFFFF);
		send_item(OP_WRITE_ALL, 2'd3, 16'h0000);
		send_item(OP_WRITE_ONE, 2'd3, 16'hFFFF);
		send_item(OP_WRITE_ONE, 2'd0, 16'd5);
		send_item(OP_NONE, 2'd2, 16'hAAAA);
		repeat (8) send_item(OP_TICK, 2'd1, 16'h5555);

		// zero slew step and zero period
		apply_settings(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0);
		send_item(OP_WRITE_ONE, 2'd0, 16'd5);
		send_item(OP_WRITE_ONE, 2'd0, 16'd6);
		send_item(OP_TICK, 2'd0, 16'd0);
		send_item(OP_TICK, 2'd0, 16'd0);

		// change equal to the step, then above it; counter left beyond a lowered period
		apply_settings(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd3, 16'd50);
		send_item(OP_WRITE_ONE, 2'd1, 16'd103);
		send_item(OP_WRITE_ONE, 2'd1, 16'd107);
		repeat (4) send_item(OP_TICK, 2'd0, 16'd0);
		apply_settings(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd3, 16'd2);
		send_item(OP_TICK, 2'd0, 16'd0);

		// random phases, the last one with no stalls or gaps
		for (int phase = 0; phase < 6; phase++) begin
			random_settings();
			gaps_on = ($urandom_range(0, 3) != 0);
			if (phase == 5) begin
				quiet   = 1'b1;
				gaps_on = 1'b0;
			end
			random_burst(22);
		end

		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
